FILE: rtl/core/lru_writeback_block_cache_ctrl_unit_macros.svh
// Assertion macros shared by the cache controller RTL.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef LRU_WRITEBACK_BLOCK_CACHE_CTRL_UNIT_MACROS_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_CTRL_UNIT_MACROS_SVH

`define LWBC_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define LWBC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LWBC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lwbc_pkg.sv
// Package of the block cache controller: sizes, payload structs, state codes.
// Used by every controller module but lwbc_ram; depends on nothing.
package lwbc_pkg;

  localparam int LINES  = 64;
  localparam int LINE_W = $clog2(LINES);
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int TAG_W  = 12;
  localparam int RANK_W = 6;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] block_number;
  } lwbc_req_t;

  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] line_index;
    logic              fill_needed;
    logic              writeback_needed;
    logic [TAG_W-1:0]  victim_block;
  } lwbc_rsp_t;

  typedef struct packed {
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } lwbc_entry_t;

  typedef struct packed {
    logic              clear;
    logic              scan_vld;
    logic              age_vld;
    logic [LINE_W-1:0] idx;
    logic [TAG_W-1:0]  blk;
    logic [CNT_W-1:0]  limit;
    logic [LINE_W-1:0] h;
    lwbc_entry_t       new_ent;
  } lwbc_cmp_ctl_t;

  typedef struct packed {
    logic              found;
    logic [LINE_W-1:0] hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              hit_dirty;
    logic [LINE_W-1:0] vic_idx;
    logic [RANK_W-1:0] vic_rank;
    logic [TAG_W-1:0]  vic_tag;
    logic              vic_dirty;
  } lwbc_cmp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_DONE
  } lwbc_state_t;

endpackage

FILE: rtl/core/lwbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the line entries of the cache controller; no dependencies.
module lwbc_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/lwbc_cmp.sv
// Shared compare unit: tag match and rank compare, one line entry per cycle.
// Gathers hit and victim data during a scan and builds aged entries; uses lwbc_pkg.
module lwbc_cmp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lwbc_pkg::lwbc_cmp_ctl_t ctl,
  input  lwbc_pkg::lwbc_entry_t   rd_ent,
  output lwbc_pkg::lwbc_cmp_sts_t sts,
  output lwbc_pkg::lwbc_entry_t   wr_ent
);
  import lwbc_pkg::*;

  logic              found_r, found_nxt;
  logic              have_r, have_nxt;
  logic [LINE_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [RANK_W-1:0] hit_rank_r, hit_rank_nxt;
  logic              hit_dirty_r, hit_dirty_nxt;
  logic [LINE_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0] vic_rank_r, vic_rank_nxt;
  logic [TAG_W-1:0]  vic_tag_r, vic_tag_nxt;
  logic              vic_dirty_r, vic_dirty_nxt;
  logic [CNT_W-1:0]  op_a;
  logic [CNT_W-1:0]  op_b;
  logic              lt;
  logic              tag_eq;

  always_comb begin
    if (ctl.age_vld) begin
      op_a = CNT_W'(rd_ent.rank);
      op_b = ctl.limit;
    end else begin
      op_a = CNT_W'(vic_rank_r);
      op_b = CNT_W'(rd_ent.rank);
    end
    lt     = op_a < op_b;
    tag_eq = rd_ent.tag == ctl.blk;
  end

  always_comb begin
    found_nxt     = found_r;
    have_nxt      = have_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_dirty_nxt = hit_dirty_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    vic_tag_nxt   = vic_tag_r;
    vic_dirty_nxt = vic_dirty_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
      have_nxt  = 1'b0;
    end else if (ctl.scan_vld) begin
      if (tag_eq && !found_r) begin
        found_nxt     = 1'b1;
        hit_idx_nxt   = ctl.idx;
        hit_rank_nxt  = rd_ent.rank;
        hit_dirty_nxt = rd_ent.dirty;
      end
      if (!have_r || lt) begin
        have_nxt      = 1'b1;
        vic_idx_nxt   = ctl.idx;
        vic_rank_nxt  = rd_ent.rank;
        vic_tag_nxt   = rd_ent.tag;
        vic_dirty_nxt = rd_ent.dirty;
      end
    end
  end

  always_comb begin
    if (ctl.idx == ctl.h) begin
      wr_ent = ctl.new_ent;
    end else begin
      wr_ent.dirty = rd_ent.dirty;
      wr_ent.tag   = rd_ent.tag;
      wr_ent.rank  = lt ? rd_ent.rank + RANK_W'(1) : rd_ent.rank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    vic_tag_r   <= vic_tag_nxt;
    vic_dirty_r <= vic_dirty_nxt;
  end

  assign sts.found     = found_r;
  assign sts.hit_idx   = hit_idx_r;
  assign sts.hit_rank  = hit_rank_r;
  assign sts.hit_dirty = hit_dirty_r;
  assign sts.vic_idx   = vic_idx_r;
  assign sts.vic_rank  = vic_rank_r;
  assign sts.vic_tag   = vic_tag_r;
  assign sts.vic_dirty = vic_dirty_r;

endmodule

FILE: rtl/core/lwbc_seq.sv
// Sequencer of the cache controller: handshakes, scan and aging passes, result.
// Drives the line RAM and the compare unit; uses lwbc_pkg and the macro header.
`include "lru_writeback_block_cache_ctrl_unit_macros.svh"

module lwbc_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lwbc_pkg::lwbc_req_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lwbc_pkg::lwbc_rsp_t          out_data,
  output lwbc_pkg::lwbc_cmp_ctl_t      cmp_ctl,
  input  lwbc_pkg::lwbc_cmp_sts_t      cmp_sts,
  output logic [lwbc_pkg::LINE_W-1:0]  ram_raddr,
  output logic                         ram_we,
  output logic [lwbc_pkg::LINE_W-1:0]  ram_waddr
);
  import lwbc_pkg::*;

  lwbc_state_t       state_r, state_nxt;
  lwbc_req_t         req_r, req_nxt;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [LINE_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [LINE_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  lwbc_entry_t       new_ent_r, new_ent_nxt;
  logic [CNT_W-1:0]  age_cnt_r, age_cnt_nxt;
  lwbc_rsp_t         rsp_r, rsp_nxt;
  logic              clear;
  logic              full;
  logic              is_write;
  logic              wb;

  assign full     = filled_r == CNT_W'(LINES);
  assign is_write = req_r.kind == KIND_WRITE;
  assign wb       = !cmp_sts.found && full && cmp_sts.vic_dirty;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    filled_nxt  = filled_r;
    issue_nxt   = issue_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = issue_r[LINE_W-1:0];
    h_nxt       = h_r;
    limit_nxt   = limit_r;
    new_ent_nxt = new_ent_r;
    age_cnt_nxt = age_cnt_r;
    rsp_nxt     = rsp_r;
    clear       = 1'b0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt   = in_data;
          issue_nxt = '0;
          clear     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_r < filled_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          if (cmp_sts.found) begin
            h_nxt       = cmp_sts.hit_idx;
            limit_nxt   = CNT_W'(cmp_sts.hit_rank);
            age_cnt_nxt = filled_r;
          end else if (full) begin
            h_nxt       = cmp_sts.vic_idx;
            limit_nxt   = CNT_W'(cmp_sts.vic_rank);
            age_cnt_nxt = filled_r;
          end else begin
            h_nxt       = filled_r[LINE_W-1:0];
            limit_nxt   = CNT_W'(LINES);
            age_cnt_nxt = filled_r + CNT_W'(1);
            filled_nxt  = filled_r + CNT_W'(1);
          end
          new_ent_nxt.dirty = cmp_sts.found ? (cmp_sts.hit_dirty | is_write) : is_write;
          new_ent_nxt.tag   = req_r.block_number;
          new_ent_nxt.rank  = '0;
          rsp_nxt.hit              = cmp_sts.found;
          rsp_nxt.line_index       = h_nxt;
          rsp_nxt.fill_needed      = !cmp_sts.found;
          rsp_nxt.writeback_needed = wb;
          rsp_nxt.victim_block     = wb ? cmp_sts.vic_tag : '0;
          issue_nxt = '0;
          state_nxt = ST_AGE;
        end
      end
      ST_AGE: begin
        if (issue_r < age_cnt_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      filled_r <= '0;
      issue_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      issue_r  <= issue_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rd_idx_r  <= rd_idx_nxt;
    h_r       <= h_nxt;
    limit_r   <= limit_nxt;
    new_ent_r <= new_ent_nxt;
    age_cnt_r <= age_cnt_nxt;
    rsp_r     <= rsp_nxt;
  end

  assign out_data  = rsp_r;
  assign ram_raddr = issue_r[LINE_W-1:0];
  assign ram_we    = (state_r == ST_AGE) && rd_vld_r;
  assign ram_waddr = rd_idx_r;

  assign cmp_ctl.clear    = clear;
  assign cmp_ctl.scan_vld = (state_r == ST_SCAN) && rd_vld_r;
  assign cmp_ctl.age_vld  = (state_r == ST_AGE) && rd_vld_r;
  assign cmp_ctl.idx      = rd_idx_r;
  assign cmp_ctl.blk      = req_r.block_number;
  assign cmp_ctl.limit    = limit_r;
  assign cmp_ctl.h        = h_r;
  assign cmp_ctl.new_ent  = new_ent_r;

  `LWBC_ASSERT_ALWAYS(a_fill_bound, filled_r <= CNT_W'(LINES), "line count exceeds line total")
  `LWBC_ASSERT_IMPLY(a_hit_xor_fill, out_valid, out_data.hit != out_data.fill_needed, "hit and fill disagree")
  `LWBC_ASSERT_IMPLY(a_wb_when_full, out_valid && out_data.writeback_needed, out_data.fill_needed && full, "writeback without a full miss")
  `LWBC_ASSERT_IMPLY(a_line_in_range, out_valid, CNT_W'(out_data.line_index) < filled_r, "result line is not in use")
  `LWBC_ASSERT_NEXT(a_count_steady, state_r != ST_SCAN, $stable(filled_r), "line count moved outside a scan")

endmodule

FILE: rtl/core/lru_writeback_block_cache_ctrl_unit.sv
// Tag and replacement controller of a fully associative write-back block cache.
// Requests arrive on the in_ channel (in_valid, in_stall, in_data); each one
// yields exactly one result on the out_ channel (out_valid, out_stall, out_data).
// A transfer happens on a rising clk edge with valid high and stall low.
// The controller handles one request at a time: in_stall is low only while idle.
// A miss that takes a free line adds that line to the lines in use. The line RAM
// has one read and one write port, so a scan pass compares one line per cycle
// against the block number and the oldest rank, and an aging pass then rewrites
// the recency rank of every line in use, again one per cycle.
// The result stays in its output register while out_stall is high; no new
// request is taken until it has been transferred.
// A synchronous active-low reset on rst_n empties the cache at once: the count
// of lines in use returns to zero, so no RAM clearing pass is needed.
// Dirty lines evicted on a miss are reported with their block number.
module lru_writeback_block_cache_ctrl_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lwbc_pkg::lwbc_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lwbc_pkg::lwbc_rsp_t out_data
);
  import lwbc_pkg::*;

  lwbc_cmp_ctl_t     cmp_ctl;
  lwbc_cmp_sts_t     cmp_sts;
  lwbc_entry_t       rd_ent;
  lwbc_entry_t       wr_ent;
  logic [LINE_W-1:0] ram_raddr;
  logic [LINE_W-1:0] ram_waddr;
  logic              ram_we;
  logic [$bits(lwbc_entry_t)-1:0] ram_rdata;

  assign rd_ent = lwbc_entry_t'(ram_rdata);

  lwbc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmp_ctl   (cmp_ctl),
    .cmp_sts   (cmp_sts),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr)
  );

  lwbc_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cmp_ctl),
    .rd_ent (rd_ent),
    .sts    (cmp_sts),
    .wr_ent (wr_ent)
  );

  lwbc_ram #(
    .WIDTH ($bits(lwbc_entry_t)),
    .DEPTH (LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
